FILE: rtl/atcl_pkg.sv
// shared types, constants and helpers for the at command line buffer
package atcl_pkg;

  localparam int DEPTH = 64;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;
  localparam int SUM_W = PTR_W + 2;

  localparam int ERR_LEN = 7;
  localparam int IDX_W   = 3;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [1:0]       kind_t;
  typedef logic [1:0]       src_t;

  localparam kind_t KIND_ERR   = 2'd0;
  localparam kind_t KIND_READY = 2'd1;
  localparam kind_t KIND_DATA  = 2'd2;
  localparam kind_t KIND_EMPTY = 2'd3;

  localparam src_t SRC_ZERO = 2'd0;
  localparam src_t SRC_MEM  = 2'd1;
  localparam src_t SRC_TEXT = 2'd2;

  localparam logic [7:0] TERM_CHAR = 8'h1A;
  localparam logic [7:0] CH_A_UP   = 8'h41;
  localparam logic [7:0] CH_A_LO   = 8'h61;
  localparam logic [7:0] CH_T_UP   = 8'h54;
  localparam logic [7:0] CH_T_LO   = 8'h74;

  typedef struct packed {
    logic  wr_en;
    logic  rd_en;
    logic  rd_next;
    logic  pop1;
    logic  pop2;
    logic  clear;
    logic  out_load;
    kind_t out_kind;
    src_t  out_src;
    idx_t  out_idx;
    logic  out_last;
  } cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic fill_full;
    logic fill_ge2;
    logic rx_term;
    logic is_a;
    logic is_t;
    logic slot_free;
  } sts_t;

  function automatic logic [7:0] err_char(idx_t idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h45;
      3'd1:    c = 8'h52;
      3'd2:    c = 8'h52;
      3'd3:    c = 8'h4F;
      3'd4:    c = 8'h52;
      3'd5:    c = 8'h0A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // circular pointer add, k never exceeds the depth
  function automatic ptr_t ptr_add(ptr_t p, cnt_t k);
    logic [SUM_W-1:0] s;
    s = {2'b00, p} + {1'b0, k};
    if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
    return s[PTR_W-1:0];
  endfunction

endpackage

FILE: rtl/atcl_datapath.sv
// byte store, pointers, fill count and output register
module atcl_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_rx_byte,
  input  atcl_pkg::cmd_t      cmd,
  output atcl_pkg::sts_t      sts,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_byte,
  output logic                out_last
);

  logic [7:0]     mem [atcl_pkg::DEPTH];
  logic [7:0]     rd_data_r;
  atcl_pkg::ptr_t rp_r, rp_nxt;
  atcl_pkg::cnt_t fill_r, fill_nxt;
  atcl_pkg::ptr_t rd_addr, wr_addr;
  logic           out_valid_r;
  logic [1:0]     out_kind_r;
  logic [7:0]     out_byte_r, out_byte_nxt;
  logic           out_last_r;

  always_comb begin
    rd_addr = cmd.rd_next ? atcl_pkg::ptr_add(rp_r, atcl_pkg::cnt_t'(1)) : rp_r;
    wr_addr = atcl_pkg::ptr_add(rp_r, fill_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= in_rx_byte;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    rp_nxt   = rp_r;
    fill_nxt = fill_r;
    priority if (cmd.clear) begin
      rp_nxt   = '0;
      fill_nxt = '0;
    end else if (cmd.wr_en) begin
      fill_nxt = fill_r + atcl_pkg::cnt_t'(1);
    end else if (cmd.pop1) begin
      rp_nxt   = atcl_pkg::ptr_add(rp_r, atcl_pkg::cnt_t'(1));
      fill_nxt = fill_r - atcl_pkg::cnt_t'(1);
    end else if (cmd.pop2) begin
      rp_nxt   = atcl_pkg::ptr_add(rp_r, atcl_pkg::cnt_t'(2));
      fill_nxt = fill_r - atcl_pkg::cnt_t'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_comb begin
    unique case (cmd.out_src)
      atcl_pkg::SRC_MEM:  out_byte_nxt = rd_data_r;
      atcl_pkg::SRC_TEXT: out_byte_nxt = atcl_pkg::err_char(cmd.out_idx);
      default:            out_byte_nxt = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind_r <= cmd.out_kind;
      out_byte_r <= out_byte_nxt;
      out_last_r <= cmd.out_last;
    end
  end

  always_comb begin
    sts.fill_zero = (fill_r == '0);
    sts.fill_full = (fill_r == atcl_pkg::cnt_t'(atcl_pkg::DEPTH));
    sts.fill_ge2  = (fill_r >= atcl_pkg::cnt_t'(2));
    sts.rx_term   = (in_rx_byte == atcl_pkg::TERM_CHAR);
    sts.is_a      = (rd_data_r == atcl_pkg::CH_A_UP) || (rd_data_r == atcl_pkg::CH_A_LO);
    sts.is_t      = (rd_data_r == atcl_pkg::CH_T_UP) || (rd_data_r == atcl_pkg::CH_T_LO);
    sts.slot_free = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

FILE: rtl/atcl_controller.sv
// state machine sequencing receive, terminator check, read and error text
module atcl_controller (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_action,
  output logic           in_stall,
  input  atcl_pkg::sts_t sts,
  output atcl_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK0 = 3'd1;
  localparam logic [2:0] S_CHK1 = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_ERR  = 3'd4;

  logic [2:0]            state_r, state_nxt;
  atcl_pkg::kind_t       kind_r, kind_nxt;
  atcl_pkg::idx_t        idx_r, idx_nxt;
  logic                  err_last;

  assign in_stall = (state_r != S_IDLE);
  assign err_last = (idx_r == atcl_pkg::idx_t'(atcl_pkg::ERR_LEN - 1));

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action) begin
            state_nxt = S_EMIT;
            if (sts.fill_zero) begin
              kind_nxt = atcl_pkg::KIND_EMPTY;
            end else begin
              kind_nxt   = atcl_pkg::KIND_DATA;
              cmd.rd_en  = 1'b1;
              cmd.pop1   = 1'b1;
            end
          end else if (sts.fill_full) begin
            cmd.clear = 1'b1;
            idx_nxt   = '0;
            state_nxt = S_ERR;
          end else begin
            cmd.wr_en = 1'b1;
            if (sts.rx_term) begin
              if (sts.fill_ge2) begin
                cmd.rd_en = 1'b1;
                state_nxt = S_CHK0;
              end else begin
                cmd.wr_en = 1'b0;
                cmd.clear = 1'b1;
                idx_nxt   = '0;
                state_nxt = S_ERR;
              end
            end
          end
        end
      end
      S_CHK0: begin
        if (sts.is_a) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          state_nxt   = S_CHK1;
        end else begin
          cmd.clear = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_ERR;
        end
      end
      S_CHK1: begin
        if (sts.is_t) begin
          cmd.pop2  = 1'b1;
          kind_nxt  = atcl_pkg::KIND_READY;
          state_nxt = S_EMIT;
        end else begin
          cmd.clear = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_ERR;
        end
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = kind_r;
          cmd.out_src  = (kind_r == atcl_pkg::KIND_DATA) ? atcl_pkg::SRC_MEM
                                                          : atcl_pkg::SRC_ZERO;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_ERR: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = atcl_pkg::KIND_ERR;
          cmd.out_src  = atcl_pkg::SRC_TEXT;
          cmd.out_idx  = idx_r;
          cmd.out_last = err_last;
          if (err_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + atcl_pkg::idx_t'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= atcl_pkg::KIND_ERR;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

FILE: rtl/at_command_line_buffer.sv
// top level of the at command line buffer
//
//   channel   direction  ports
//   in        input      in_valid, in_stall, in_action, in_rx_byte
//   out       output     out_valid, out_stall, out_kind, out_byte, out_last
//
// an ordinary byte is written in IDLE, a read passes EMIT, a matched terminator
// passes CHK0, CHK1, EMIT, set by the byte store's single read port, checked one
// byte per cycle; an error run sends 7 text bytes through the output register
// reset clears pointers, fill count, controller and output valid; no clearing pass
// out_stall holds the output register and the controller waits on it
module at_command_line_buffer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last
);

  atcl_pkg::cmd_t cmd;
  atcl_pkg::sts_t sts;

  atcl_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  atcl_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_rx_byte (in_rx_byte),
    .cmd        (cmd),
    .sts        (sts),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule

FILE: rtl/atcl_checker.sv
// port level checks for the at command line buffer and their binding
module atcl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_kind) && $stable(out_byte) && $stable(out_last))
    else $error("result payload changed while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != atcl_pkg::KIND_ERR) |-> out_last)
    else $error("single result transaction without last");

  a_err_nul_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == atcl_pkg::KIND_ERR) |-> (out_last == (out_byte == 8'h00)))
    else $error("error text end not marked by nul");

endmodule

bind at_command_line_buffer atcl_checker u_atcl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_kind  (out_kind),
  .out_byte  (out_byte),
  .out_last  (out_last)
);

FILE: test/tb_top.sv
// self-checking testbench for the at command line buffer with a scoreboard class
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACT_RX   = 1'b0;
  localparam logic ACT_READ = 1'b1;

  class cmd_line_scoreboard;
    typedef struct packed {
      atcl_pkg::kind_t kind;
      logic [7:0]      data;
      logic            last;
    } line_result_t;

    line_result_t   line_results_q[$];
    logic [7:0]     line_mem [atcl_pkg::DEPTH];
    atcl_pkg::ptr_t head_ptr;
    atcl_pkg::cnt_t held_cnt;
    int             errors;

    function new();
      head_ptr = '0;
      held_cnt = '0;
      errors   = 0;
    endfunction

    function int outstanding();
      return line_results_q.size();
    endfunction

    function void push_result(atcl_pkg::kind_t k, logic [7:0] d, logic l);
      line_result_t r;
      r.kind = k;
      r.data = d;
      r.last = l;
      line_results_q.push_back(r);
    endfunction

    function logic [7:0] pop_oldest(output bit got);
      logic [7:0] v;
      v = 8'h00;
      got = (held_cnt != 0);
      if (got) begin
        v = line_mem[head_ptr];
        head_ptr = atcl_pkg::ptr_t'((int'(head_ptr) + 1) % atcl_pkg::DEPTH);
        held_cnt = held_cnt - atcl_pkg::cnt_t'(1);
      end
      return v;
    endfunction

    // "ERROR\n" followed by a nul, then the buffer is emptied
    function void push_error_text();
      string txt;
      txt = "ERROR\n";
      for (int i = 0; i < atcl_pkg::ERR_LEN; i++) begin
        push_result(atcl_pkg::KIND_ERR, (i < txt.len()) ? txt[i] : 8'h00,
                    i == atcl_pkg::ERR_LEN - 1);
      end
      head_ptr = '0;
      held_cnt = '0;
    endfunction

    function void note_item(logic act, logic [7:0] b);
      bit got;
      logic [7:0] c0;
      logic [7:0] c1;
      if (act == ACT_READ) begin
        c0 = pop_oldest(got);
        if (got) push_result(atcl_pkg::KIND_DATA, c0, 1'b1);
        else push_result(atcl_pkg::KIND_EMPTY, 8'h00, 1'b1);
        return;
      end
      if (held_cnt >= atcl_pkg::DEPTH) begin
        push_error_text();
        return;
      end
      line_mem[(int'(head_ptr) + int'(held_cnt)) % atcl_pkg::DEPTH] = b;
      held_cnt = held_cnt + atcl_pkg::cnt_t'(1);
      if (b == atcl_pkg::TERM_CHAR) begin
        c0 = pop_oldest(got);
        c1 = pop_oldest(got);
        if ((c0 == atcl_pkg::CH_A_UP || c0 == atcl_pkg::CH_A_LO) &&
            (c1 == atcl_pkg::CH_T_UP || c1 == atcl_pkg::CH_T_LO)) begin
          push_result(atcl_pkg::KIND_READY, 8'h00, 1'b1);
        end else begin
          push_error_text();
        end
      end
    endfunction

    function void check_result(atcl_pkg::kind_t k, logic [7:0] d, logic l);
      line_result_t e;
      if (line_results_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind %0d data %h last %b",
                 $time, k, d, l);
        return;
      end
      e = line_results_q.pop_front();
      if (e.kind !== k || e.data !== d || e.last !== l) begin
        errors++;
        $display("%0t: result mismatch, expected kind %0d data %h last %b, %s",
                 $time, e.kind, e.data, e.last,
                 $sformatf("got kind %0d data %h last %b", k, d, l));
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_action = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;

  cmd_line_scoreboard sb = new();

  int items_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int idle_tab[4]  = '{0, 49, 0, 13};
  int stall_tab[4] = '{0, 0, 49, 13};

  at_command_line_buffer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_action  (in_action),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_kind, out_byte, out_last);
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic send_item(logic act, logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_item(act, b);
    items_sent++;
  endtask

  task automatic send_read();
    send_item(ACT_READ, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == atcl_pkg::TERM_CHAR);
    return b;
  endfunction

  function automatic logic [7:0] near_miss_byte();
    unique case ($urandom_range(0, 4))
      0:       return atcl_pkg::CH_A_UP;
      1:       return atcl_pkg::CH_A_LO;
      2:       return atcl_pkg::CH_T_UP;
      3:       return atcl_pkg::CH_T_LO;
      default: return plain_byte();
    endcase
  endfunction

  task automatic drain_fifo();
    while (sb.held_cnt != 0) send_read();
  endtask

  // sender holds off until every pending result has come back
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic fill_to_overflow();
    while (sb.held_cnt < atcl_pkg::DEPTH) send_item(ACT_RX, plain_byte());
    send_item(ACT_RX, ($urandom_range(0, 1) != 0) ? atcl_pkg::TERM_CHAR
                                                  : 8'($urandom_range(0, 255)));
  endtask

  task automatic run_random(int n);
    int stop;
    int pick;
    int k;
    stop = items_sent + n;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        if ($urandom_range(0, 3) != 0) drain_fifo();
        send_item(ACT_RX, ($urandom_range(0, 1) != 0) ? atcl_pkg::CH_A_UP : atcl_pkg::CH_A_LO);
        send_item(ACT_RX, ($urandom_range(0, 1) != 0) ? atcl_pkg::CH_T_UP : atcl_pkg::CH_T_LO);
        k = $urandom_range(0, 5);
        repeat (k) send_item(ACT_RX, plain_byte());
        send_item(ACT_RX, atcl_pkg::TERM_CHAR);
        k = $urandom_range(0, 3);
        repeat (k) send_read();
      end else if (pick < 55) begin
        if ($urandom_range(0, 1) != 0) drain_fifo();
        k = $urandom_range(0, 2);
        repeat (k) send_item(ACT_RX, near_miss_byte());
        send_item(ACT_RX, atcl_pkg::TERM_CHAR);
      end else if (pick < 80) begin
        repeat (4) begin
          send_item(1'($urandom_range(0, 1)),
                    ($urandom_range(0, 5) == 0) ? atcl_pkg::TERM_CHAR
                                                : 8'($urandom_range(0, 255)));
        end
      end else if (pick < 98) begin
        k = $urandom_range(1, 4);
        repeat (k) send_read();
      end else begin
        fill_to_overflow();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty read, lone terminator, each letter case pairing, leftover terminator
    send_read();
    send_item(ACT_RX, atcl_pkg::TERM_CHAR);
    send_item(ACT_RX, atcl_pkg::CH_A_UP);
    send_item(ACT_RX, atcl_pkg::CH_T_UP);
    send_item(ACT_RX, atcl_pkg::TERM_CHAR);
    send_read();
    send_item(ACT_RX, atcl_pkg::CH_A_LO);
    send_item(ACT_RX, atcl_pkg::CH_T_LO);
    send_item(ACT_RX, atcl_pkg::TERM_CHAR);
    send_read();
    send_item(ACT_RX, atcl_pkg::CH_A_LO);
    send_item(ACT_RX, atcl_pkg::CH_T_UP);
    send_item(ACT_RX, atcl_pkg::TERM_CHAR);
    send_read();
    send_item(ACT_RX, atcl_pkg::CH_A_UP);
    send_item(ACT_RX, atcl_pkg::CH_T_LO);
    send_item(ACT_RX, atcl_pkg::TERM_CHAR);
    send_read();
    send_item(ACT_RX, 8'h00);
    send_item(ACT_RX, 8'hFF);
    send_item(ACT_RX, atcl_pkg::TERM_CHAR);
    send_item(ACT_RX, atcl_pkg::CH_A_UP);
    send_item(ACT_RX, atcl_pkg::TERM_CHAR);
    send_read();
    quiesce();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_tab[p];
      stall_pct = stall_tab[p];
      if (p == 1) fill_to_overflow();
      run_random(60);
      quiesce();
    end

    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
